[hw/rtl/urf_pkg.sv]
`default_nettype none
package urf_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam int TRIG_QUARTER = (FIFO_DEPTH / 4 < 1) ? 1 : FIFO_DEPTH / 4;
    localparam int TRIG_HALF    = (FIFO_DEPTH / 2 < 1) ? 1 : FIFO_DEPTH / 2;
    localparam int TRIG_NEAR    = (FIFO_DEPTH - 2 < 1) ? 1 : FIFO_DEPTH - 2;

    localparam logic [7:0] IIR_CHAR_MODE = 8'h01;
    localparam logic [7:0] IIR_FIFO_MODE = 8'hC1;

    localparam int LSR_DR   = 0;
    localparam int LSR_OE   = 1;
    localparam int LSR_PE   = 2;
    localparam int LSR_FE   = 3;
    localparam int LSR_BI   = 4;
    localparam int LSR_THR_EMPTY = 5;
    localparam int LSR_TEMT = 6;
    localparam int LSR_ERR  = 7;

    localparam int LCR_DLAB = 7;
    localparam int FCR_EN   = 0;
    localparam int FCR_RXCLR = 1;
    localparam int FCR_TXCLR = 2;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_RX    = 2'd2,
        CMD_PULL  = 2'd3
    } urf_cmd_t;

    typedef enum logic [2:0] {
        REG_RBR = 3'd0,
        REG_IER = 3'd1,
        REG_IIR = 3'd2,
        REG_LCR = 3'd3,
        REG_MCR = 3'd4,
        REG_LSR = 3'd5,
        REG_MSR = 3'd6,
        REG_SCR = 3'd7
    } urf_reg_t;

    typedef struct packed {
        urf_cmd_t   command;
        urf_reg_t   reg_index;
        logic [7:0] write_data;
        logic [7:0] rx_byte;
        logic       rx_parity_error;
        logic       rx_framing_error;
        logic       rx_break;
    } urf_in_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [15:0] divisor;
        logic [7:0]  line_control;
        logic        dtr_out;
        logic        rts_out;
        logic        rx_level_reached;
        logic        tx_empty;
    } urf_out_t;

    typedef struct packed {
        logic       brk;
        logic       framing;
        logic       parity;
        logic [7:0] data;
    } urf_rx_entry_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        logic overwrite;
    } urf_rx_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] count_next;
        urf_rx_entry_t    head;
        logic             err_any;
    } urf_rx_stat_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } urf_tx_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] count_next;
        logic [7:0]       head;
    } urf_tx_stat_t;

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr == PTR_W'(FIFO_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + PTR_W'(1);
        end
        return nxt;
    endfunction

    function automatic logic [CNT_W-1:0] trig_level(input logic [1:0] code);
        logic [CNT_W-1:0] lvl;
        unique case (code)
            2'd0: lvl = CNT_W'(1);
            2'd1: lvl = CNT_W'(TRIG_QUARTER);
            2'd2: lvl = CNT_W'(TRIG_HALF);
            default: lvl = CNT_W'(TRIG_NEAR);
        endcase
        return lvl;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/urf_rx_fifo.sv]
`default_nettype none
module urf_rx_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire urf_pkg::urf_rx_ctrl_t ctrl,
    input  wire urf_pkg::urf_rx_entry_t entry,
    output urf_pkg::urf_rx_stat_t      stat
);
    import urf_pkg::*;

    urf_rx_entry_t    store_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] err_reg, err_next;
    urf_rx_entry_t    head_entry;
    logic             head_err;
    logic             new_err;

    assign head_entry = store_reg[head_reg];
    assign head_err   = head_entry.brk | head_entry.framing | head_entry.parity;
    assign new_err    = entry.brk | entry.framing | entry.parity;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        err_next   = err_reg;
        priority if (ctrl.clear) begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
            err_next   = '0;
        end else if (ctrl.push) begin
            tail_next  = wrap_next(tail_reg);
            count_next = count_reg + CNT_W'(1);
            err_next   = err_reg + CNT_W'(new_err);
        end else if (ctrl.pop) begin
            head_next  = wrap_next(head_reg);
            count_next = count_reg - CNT_W'(1);
            err_next   = err_reg - CNT_W'(head_err);
        end else if (ctrl.overwrite) begin
            err_next   = err_reg - CNT_W'(head_err) + CNT_W'(new_err);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            err_reg   <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!ctrl.clear && ctrl.push) begin
            store_reg[tail_reg] <= entry;
        end else if (!ctrl.clear && ctrl.overwrite) begin
            store_reg[head_reg] <= entry;
        end
    end

    assign stat.count      = count_reg;
    assign stat.count_next = count_next;
    assign stat.head       = head_entry;
    assign stat.err_any    = (err_reg != '0);

endmodule
`default_nettype wire

[hw/rtl/urf_tx_fifo.sv]
`default_nettype none
module urf_tx_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire urf_pkg::urf_tx_ctrl_t ctrl,
    input  wire logic [7:0]            wr_data,
    output urf_pkg::urf_tx_stat_t      stat
);
    import urf_pkg::*;

    logic [7:0]       store_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        priority if (ctrl.clear) begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end else if (ctrl.push) begin
            tail_next  = wrap_next(tail_reg);
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.pop) begin
            head_next  = wrap_next(head_reg);
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!ctrl.clear && ctrl.push) begin
            store_reg[tail_reg] <= wr_data;
        end
    end

    assign stat.count      = count_reg;
    assign stat.count_next = count_next;
    assign stat.head       = store_reg[head_reg];

endmodule
`default_nettype wire

[hw/rtl/uart_register_file_with_fifos_top.sv]
`default_nettype none
// Register side of a 16550-style UART. Each input beat is one event: a bus read or
// write at register index 0..7, a received byte with its error flags, or a pull by
// the transmitter; each produces exactly one result beat carrying the read data,
// the pulled byte and the current divisor, line control, DTR/RTS, receive trigger
// and transmit empty status. Beats are taken one per cycle with no gaps while the
// result side is not stalled by m_ready; each event passes the input register, then
// the result register, and the register file and both FIFOs are updated as the event
// leaves the input register. Both FIFOs are FIFO_DEPTH entries of flip-flops; with
// FIFOs disabled each holds a single byte.
module uart_register_file_with_fifos_top (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire urf_pkg::urf_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output urf_pkg::urf_out_t     m_data
);
    import urf_pkg::*;

    logic             in_valid_reg;
    urf_in_t          in_data_reg;
    logic             out_valid_reg;
    urf_out_t         out_data_reg, out_data_next;
    logic             advance;

    logic [15:0]      div_reg, div_next;
    logic [3:0]       ier_reg, ier_next;
    logic [7:0]       lcr_reg, lcr_next;
    logic [7:0]       mcr_reg, mcr_next;
    logic             fifo_en_reg, fifo_en_next;
    logic [1:0]       trig_reg, trig_next;
    logic             overrun_reg, overrun_next;
    logic [7:0]       scr_reg, scr_next;

    urf_rx_ctrl_t     rx_ctrl;
    urf_rx_stat_t     rx_stat;
    urf_rx_entry_t    rx_entry;
    urf_tx_ctrl_t     tx_ctrl;
    urf_tx_stat_t     tx_stat;

    logic             dlab;
    logic [CNT_W-1:0] cap;
    logic [7:0]       lsr;
    logic [7:0]       rd;
    logic             tv;
    logic [7:0]       tb;
    logic [7:0]       wd;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign dlab = lcr_reg[LCR_DLAB];
    assign cap  = fifo_en_reg ? CNT_W'(FIFO_DEPTH) : CNT_W'(1);
    assign wd   = in_data_reg.write_data;

    assign rx_entry.brk     = in_data_reg.rx_break;
    assign rx_entry.framing = in_data_reg.rx_framing_error;
    assign rx_entry.parity  = in_data_reg.rx_parity_error;
    assign rx_entry.data    = in_data_reg.rx_byte;

    always_comb begin
        lsr = '0;
        if (rx_stat.count != '0) begin
            lsr[LSR_DR]  = 1'b1;
            lsr[LSR_PE]  = rx_stat.head.parity;
            lsr[LSR_FE]  = rx_stat.head.framing;
            lsr[LSR_BI]  = rx_stat.head.brk;
            lsr[LSR_ERR] = fifo_en_reg && rx_stat.err_any;
        end
        lsr[LSR_OE]   = overrun_reg;
        lsr[LSR_THR_EMPTY] = (tx_stat.count == '0);
        lsr[LSR_TEMT] = (tx_stat.count == '0);
    end

    always_comb begin
        div_next     = div_reg;
        ier_next     = ier_reg;
        lcr_next     = lcr_reg;
        mcr_next     = mcr_reg;
        fifo_en_next = fifo_en_reg;
        trig_next    = trig_reg;
        overrun_next = overrun_reg;
        scr_next     = scr_reg;
        rx_ctrl      = '0;
        tx_ctrl      = '0;
        rd           = '0;
        tv           = 1'b0;
        tb           = '0;
        if (advance) begin
            unique case (in_data_reg.command)
                CMD_READ: begin
                    unique case (in_data_reg.reg_index)
                        REG_RBR: begin
                            if (dlab) begin
                                rd = div_reg[7:0];
                            end else if (rx_stat.count != '0) begin
                                rd = rx_stat.head.data;
                                rx_ctrl.pop = 1'b1;
                            end
                        end
                        REG_IER: rd = dlab ? div_reg[15:8] : {4'b0, ier_reg};
                        REG_IIR: rd = fifo_en_reg ? IIR_FIFO_MODE : IIR_CHAR_MODE;
                        REG_LCR: rd = lcr_reg;
                        REG_MCR: rd = mcr_reg;
                        REG_LSR: begin
                            rd = lsr;
                            overrun_next = 1'b0;
                        end
                        REG_MSR: rd = '0;
                        REG_SCR: rd = scr_reg;
                        default: rd = '0;
                    endcase
                end
                CMD_WRITE: begin
                    unique case (in_data_reg.reg_index)
                        REG_RBR: begin
                            if (dlab) begin
                                div_next[7:0] = wd;
                            end else if (tx_stat.count < cap) begin
                                tx_ctrl.push = 1'b1;
                            end
                        end
                        REG_IER: begin
                            if (dlab) begin
                                div_next[15:8] = wd;
                            end else begin
                                ier_next = wd[3:0];
                            end
                        end
                        REG_IIR: begin
                            if (wd[FCR_EN] != fifo_en_reg) begin
                                rx_ctrl.clear = 1'b1;
                                tx_ctrl.clear = 1'b1;
                            end
                            fifo_en_next = wd[FCR_EN];
                            if (wd[FCR_EN]) begin
                                if (wd[FCR_RXCLR]) rx_ctrl.clear = 1'b1;
                                if (wd[FCR_TXCLR]) tx_ctrl.clear = 1'b1;
                                trig_next = wd[7:6];
                            end
                        end
                        REG_LCR: lcr_next = wd;
                        REG_MCR: mcr_next = wd;
                        REG_SCR: scr_next = wd;
                        default: ;
                    endcase
                end
                CMD_RX: begin
                    if (rx_stat.count < cap) begin
                        rx_ctrl.push = 1'b1;
                    end else begin
                        overrun_next = 1'b1;
                        if (!fifo_en_reg && rx_stat.count != '0) rx_ctrl.overwrite = 1'b1;
                    end
                end
                CMD_PULL: begin
                    if (tx_stat.count != '0) begin
                        tv = 1'b1;
                        tb = tx_stat.head;
                        tx_ctrl.pop = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        out_data_next.read_data    = rd;
        out_data_next.tx_valid     = tv;
        out_data_next.tx_byte      = tb;
        out_data_next.divisor      = div_next;
        out_data_next.line_control = lcr_next;
        out_data_next.dtr_out      = mcr_next[0];
        out_data_next.rts_out      = mcr_next[1];
        out_data_next.rx_level_reached = fifo_en_next
            ? (rx_stat.count_next >= trig_level(trig_next))
            : (rx_stat.count_next != '0);
        out_data_next.tx_empty     = (tx_stat.count_next == '0);
    end

    urf_rx_fifo u_rx_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rx_ctrl),
        .entry   (rx_entry),
        .stat    (rx_stat)
    );

    urf_tx_fifo u_tx_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tx_ctrl),
        .wr_data (wd),
        .stat    (tx_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            div_reg       <= '0;
            ier_reg       <= '0;
            lcr_reg       <= '0;
            mcr_reg       <= '0;
            fifo_en_reg   <= 1'b0;
            trig_reg      <= '0;
            overrun_reg   <= 1'b0;
            scr_reg       <= '0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            div_reg     <= div_next;
            ier_reg     <= ier_next;
            lcr_reg     <= lcr_next;
            mcr_reg     <= mcr_next;
            fifo_en_reg <= fifo_en_next;
            trig_reg    <= trig_next;
            overrun_reg <= overrun_next;
            scr_reg     <= scr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_data_reg <= s_data;
        if (advance) out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

[sim/tb.sv]
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import urf_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned DRAIN_TAIL      = 8;
    localparam int unsigned ITEMS_PER_PHASE = 300;

    typedef enum int {
        BURST_MIX,
        BURST_RX_FILL,
        BURST_RX_DRAIN,
        BURST_TX_FILL,
        BURST_TX_DRAIN
    } burst_t;

    typedef struct {
        urf_in_t  beat;
        bit       typed;
        urf_out_t want;
    } script_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    urf_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    urf_out_t m_data;

    uart_register_file_with_fifos_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // shadow of the register file and both FIFOs
    urf_rx_entry_t rx_fifo[$];
    logic [7:0]    tx_fifo[$];
    logic [15:0]   div_q    = '0;
    logic [3:0]    ier_q    = '0;
    logic [7:0]    lcr_q    = '0;
    logic [7:0]    mcr_q    = '0;
    logic [7:0]    scr_q    = '0;
    logic          fifo_on  = 1'b0;
    logic          ovr_q    = 1'b0;
    logic [1:0]    trig_q   = '0;

    int unsigned trig_of_code[4] = '{1, FIFO_DEPTH / 4, FIFO_DEPTH / 2, FIFO_DEPTH - 2};
    int unsigned gap_by_phase[4]   = '{0, 54, 0, 33};
    int unsigned stall_by_phase[4] = '{0, 0, 54, 33};

    urf_out_t    due_out[$];
    script_row_t script[$];

    int unsigned gap_pct      = 0;
    int unsigned stall_pct    = 0;
    int unsigned mismatches   = 0;
    int unsigned beats_in     = 0;
    int unsigned results_seen = 0;
    int unsigned idle_cycles  = 0;
    int unsigned fifo_entries = 0;
    int unsigned rx_overruns  = 0;
    int unsigned rx_deepest   = 0;

    function automatic urf_out_t apply_event(input urf_in_t b);
        urf_out_t      o;
        urf_rx_entry_t e;
        logic          dlab;
        logic [7:0]    lsr;
        int unsigned   cap;
        int unsigned   lvl;
        o    = '0;
        dlab = lcr_q[LCR_DLAB];
        cap  = fifo_on ? FIFO_DEPTH : 1;
        case (b.command)
            CMD_READ: begin
                case (b.reg_index)
                    REG_RBR: begin
                        if (dlab) begin
                            o.read_data = div_q[7:0];
                        end else if (rx_fifo.size() != 0) begin
                            e = rx_fifo.pop_front();
                            o.read_data = e.data;
                        end
                    end
                    REG_IER: o.read_data = dlab ? div_q[15:8] : {4'h0, ier_q};
                    REG_IIR: o.read_data = fifo_on ? IIR_FIFO_MODE : IIR_CHAR_MODE;
                    REG_LCR: o.read_data = lcr_q;
                    REG_MCR: o.read_data = mcr_q;
                    REG_LSR: begin
                        lsr = '0;
                        if (rx_fifo.size() != 0) begin
                            lsr[LSR_DR] = 1'b1;
                            lsr[LSR_PE] = rx_fifo[0].parity;
                            lsr[LSR_FE] = rx_fifo[0].framing;
                            lsr[LSR_BI] = rx_fifo[0].brk;
                            if (fifo_on) begin
                                foreach (rx_fifo[i]) begin
                                    if (rx_fifo[i].parity || rx_fifo[i].framing ||
                                        rx_fifo[i].brk) begin
                                        lsr[LSR_ERR] = 1'b1;
                                    end
                                end
                            end
                        end
                        lsr[LSR_OE]   = ovr_q;
                        lsr[LSR_THR_EMPTY] = (tx_fifo.size() == 0);
                        lsr[LSR_TEMT] = (tx_fifo.size() == 0);
                        o.read_data   = lsr;
                        ovr_q         = 1'b0;
                    end
                    REG_MSR: o.read_data = 8'h00;
                    default: o.read_data = scr_q;
                endcase
            end
            CMD_WRITE: begin
                case (b.reg_index)
                    REG_RBR: begin
                        if (dlab) begin
                            div_q[7:0] = b.write_data;
                        end else if (tx_fifo.size() < cap) begin
                            tx_fifo.push_back(b.write_data);
                        end
                    end
                    REG_IER: begin
                        if (dlab) begin
                            div_q[15:8] = b.write_data;
                        end else begin
                            ier_q = b.write_data[3:0];
                        end
                    end
                    REG_IIR: begin
                        if (b.write_data[FCR_EN] != fifo_on) begin
                            rx_fifo.delete();
                            tx_fifo.delete();
                            if (b.write_data[FCR_EN]) begin
                                fifo_entries++;
                            end
                        end
                        fifo_on = b.write_data[FCR_EN];
                        if (fifo_on) begin
                            if (b.write_data[FCR_RXCLR]) begin
                                rx_fifo.delete();
                            end
                            if (b.write_data[FCR_TXCLR]) begin
                                tx_fifo.delete();
                            end
                            trig_q = b.write_data[7:6];
                        end
                    end
                    REG_LCR: lcr_q = b.write_data;
                    REG_MCR: mcr_q = b.write_data;
                    REG_SCR: scr_q = b.write_data;
                    default: ;
                endcase
            end
            CMD_RX: begin
                e.brk     = b.rx_break;
                e.framing = b.rx_framing_error;
                e.parity  = b.rx_parity_error;
                e.data    = b.rx_byte;
                if (rx_fifo.size() < cap) begin
                    rx_fifo.push_back(e);
                end else begin
                    ovr_q = 1'b1;
                    rx_overruns++;
                    if (!fifo_on && rx_fifo.size() != 0) begin
                        rx_fifo[0] = e;
                    end
                end
                if (rx_fifo.size() > rx_deepest) begin
                    rx_deepest = rx_fifo.size();
                end
            end
            default: begin
                if (tx_fifo.size() != 0) begin
                    o.tx_valid = 1'b1;
                    o.tx_byte  = tx_fifo.pop_front();
                end
            end
        endcase
        lvl = trig_of_code[trig_q];
        if (lvl < 1) begin
            lvl = 1;
        end
        o.divisor          = div_q;
        o.line_control     = lcr_q;
        o.dtr_out          = mcr_q[0];
        o.rts_out          = mcr_q[1];
        o.rx_level_reached = fifo_on ? (rx_fifo.size() >= lvl) : (rx_fifo.size() >= 1);
        o.tx_empty         = (tx_fifo.size() == 0);
        return o;
    endfunction

    function automatic urf_in_t ev(input urf_cmd_t c, input urf_reg_t r,
                                   input logic [7:0] d, input logic [7:0] rb = 8'h00,
                                   input logic [2:0] errs = 3'b000);
        urf_in_t b;
        b.command          = c;
        b.reg_index        = r;
        b.write_data       = d;
        b.rx_byte          = rb;
        b.rx_break         = errs[2];
        b.rx_framing_error = errs[1];
        b.rx_parity_error  = errs[0];
        return b;
    endfunction

    function automatic urf_out_t res(input logic [7:0] rd, input logic [15:0] dv,
                                     input logic [7:0] lc, input logic txe);
        urf_out_t o;
        o              = '0;
        o.read_data    = rd;
        o.divisor      = dv;
        o.line_control = lc;
        o.tx_empty     = txe;
        return o;
    endfunction

    function automatic urf_in_t rand_event(input burst_t mode);
        urf_in_t     b;
        int unsigned r;
        r                  = $urandom_range(99);
        b.command          = urf_cmd_t'($urandom_range(3));
        b.reg_index        = urf_reg_t'($urandom_range(7));
        b.write_data       = 8'($urandom_range(255));
        b.rx_byte          = 8'($urandom_range(255));
        b.rx_parity_error  = ($urandom_range(3) == 0);
        b.rx_framing_error = ($urandom_range(3) == 0);
        b.rx_break         = ($urandom_range(5) == 0);
        if (b.command == CMD_WRITE && b.reg_index == REG_LCR) begin
            b.write_data[LCR_DLAB] = ($urandom_range(3) == 0);
        end
        if (b.command == CMD_WRITE && b.reg_index == REG_IIR) begin
            b.write_data[FCR_EN]    = ($urandom_range(3) != 0);
            b.write_data[FCR_RXCLR] = ($urandom_range(3) == 0);
            b.write_data[FCR_TXCLR] = ($urandom_range(3) == 0);
        end
        if (r >= 12 && mode != BURST_MIX) begin
            if (lcr_q[LCR_DLAB]) begin
                b.command              = CMD_WRITE;
                b.reg_index            = REG_LCR;
                b.write_data[LCR_DLAB] = 1'b0;
            end else begin
                case (mode)
                    BURST_RX_FILL: begin
                        b.command   = (r < 75) ? CMD_RX : CMD_READ;
                        b.reg_index = (r < 88) ? REG_LSR : REG_RBR;
                    end
                    BURST_RX_DRAIN: begin
                        b.command   = (r < 85) ? CMD_READ : CMD_RX;
                        b.reg_index = (r < 70) ? REG_RBR : REG_LSR;
                    end
                    BURST_TX_FILL: begin
                        b.command   = (r < 75) ? CMD_WRITE : CMD_PULL;
                        b.reg_index = REG_RBR;
                    end
                    default: begin
                        b.command   = (r < 75) ? CMD_PULL : CMD_WRITE;
                        b.reg_index = REG_RBR;
                    end
                endcase
            end
        end
        return b;
    endfunction

    task automatic add_row(input urf_in_t b, input bit typed, input urf_out_t want = '0);
        script_row_t row;
        row.beat  = b;
        row.typed = typed;
        row.want  = want;
        script.push_back(row);
    endtask

    task automatic send_beat(input urf_in_t b, input bit typed, input urf_out_t want);
        urf_out_t got;
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        got = apply_event(b);
        due_out.push_back(typed ? want : got);
        beats_in++;
    endtask

    task automatic report_mismatch(input string what, input int unsigned seen,
                                   input int unsigned want);
        $display("mismatch at result beat %0d: %s got 0x%0h, want 0x%0h",
                 results_seen, what, seen, want);
        mismatches++;
    endtask

    task automatic check_result(input urf_out_t got);
        urf_out_t want;
        if (due_out.size() == 0) begin
            report_mismatch("unexpected beat, read_data", got.read_data, 0);
        end else begin
            want = due_out.pop_front();
            if (got.read_data !== want.read_data)
                report_mismatch("read_data", got.read_data, want.read_data);
            if (got.tx_valid !== want.tx_valid)
                report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
            if (got.tx_byte !== want.tx_byte)
                report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
            if (got.divisor !== want.divisor)
                report_mismatch("divisor", got.divisor, want.divisor);
            if (got.line_control !== want.line_control)
                report_mismatch("line_control", got.line_control, want.line_control);
            if (got.dtr_out !== want.dtr_out)
                report_mismatch("dtr_out", got.dtr_out, want.dtr_out);
            if (got.rts_out !== want.rts_out)
                report_mismatch("rts_out", got.rts_out, want.rts_out);
            if (got.rx_level_reached !== want.rx_level_reached)
                report_mismatch("rx_level_reached", got.rx_level_reached,
                                want.rx_level_reached);
            if (got.tx_empty !== want.tx_empty)
                report_mismatch("tx_empty", got.tx_empty, want.tx_empty);
        end
        results_seen++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        urf_in_t     b;
        burst_t      mode;
        int unsigned burst_len;
        int unsigned counted;

        add_row(ev(CMD_READ,  REG_IIR, 8'h00), 1'b1, res(IIR_CHAR_MODE, 16'h0000, 8'h00, 1'b1));
        add_row(ev(CMD_READ,  REG_LSR, 8'h00), 1'b1, res(8'h60, 16'h0000, 8'h00, 1'b1));
        add_row(ev(CMD_READ,  REG_MSR, 8'hFF), 1'b1, res(8'h00, 16'h0000, 8'h00, 1'b1));
        add_row(ev(CMD_READ,  REG_RBR, 8'h00), 1'b1, res(8'h00, 16'h0000, 8'h00, 1'b1));
        add_row(ev(CMD_PULL,  REG_RBR, 8'h00), 1'b1, res(8'h00, 16'h0000, 8'h00, 1'b1));
        add_row(ev(CMD_WRITE, REG_LCR, 8'h80), 1'b1, res(8'h00, 16'h0000, 8'h80, 1'b1));
        add_row(ev(CMD_WRITE, REG_RBR, 8'hFF), 1'b1, res(8'h00, 16'h00FF, 8'h80, 1'b1));
        add_row(ev(CMD_WRITE, REG_IER, 8'hFF), 1'b1, res(8'h00, 16'hFFFF, 8'h80, 1'b1));
        add_row(ev(CMD_READ,  REG_RBR, 8'h00), 1'b0);
        add_row(ev(CMD_READ,  REG_IER, 8'h00), 1'b0);
        add_row(ev(CMD_WRITE, REG_LCR, 8'h00), 1'b1, res(8'h00, 16'hFFFF, 8'h00, 1'b1));
        add_row(ev(CMD_WRITE, REG_IER, 8'hFF), 1'b0);
        add_row(ev(CMD_READ,  REG_IER, 8'h00), 1'b0);
        add_row(ev(CMD_WRITE, REG_MCR, 8'hFF), 1'b0);
        add_row(ev(CMD_WRITE, REG_SCR, 8'hFF), 1'b0);
        add_row(ev(CMD_READ,  REG_SCR, 8'h00), 1'b0);
        add_row(ev(CMD_WRITE, REG_LSR, 8'hFF), 1'b0);
        add_row(ev(CMD_WRITE, REG_MSR, 8'hFF), 1'b0);
        add_row(ev(CMD_RX,    REG_RBR, 8'h00, 8'h00, 3'b111), 1'b0);
        add_row(ev(CMD_RX,    REG_RBR, 8'h00, 8'hFF, 3'b000), 1'b0);
        add_row(ev(CMD_READ,  REG_LSR, 8'h00), 1'b0);
        add_row(ev(CMD_READ,  REG_RBR, 8'h00), 1'b0);
        add_row(ev(CMD_WRITE, REG_RBR, 8'h00), 1'b0);
        add_row(ev(CMD_WRITE, REG_RBR, 8'hFF), 1'b0);
        add_row(ev(CMD_PULL,  REG_RBR, 8'h00), 1'b0);
        add_row(ev(CMD_WRITE, REG_IIR, 8'hC6), 1'b0);
        add_row(ev(CMD_WRITE, REG_IIR, 8'hC7), 1'b0);
        add_row(ev(CMD_READ,  REG_IIR, 8'h00), 1'b0);
        add_row(ev(CMD_WRITE, REG_IIR, 8'h00), 1'b0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            send_beat(script[i].beat, script[i].typed, script[i].want);
        end

        for (int p = 0; p < 4; p++) begin
            gap_pct   = gap_by_phase[p];
            stall_pct = stall_by_phase[p];
            counted   = 0;
            while (counted < ITEMS_PER_PHASE) begin
                mode      = burst_t'($urandom_range(4));
                burst_len = $urandom_range(50, 20);
                if ($urandom_range(1) == 1) begin
                    b = ev(CMD_WRITE, REG_IIR, 8'($urandom_range(255)));
                    b.write_data[FCR_EN] = ($urandom_range(3) != 0);
                    send_beat(b, 1'b0, '0);
                    counted++;
                end
                for (int k = 0; k < burst_len; k++) begin
                    b = rand_event(mode);
                    send_beat(b, 1'b0, '0);
                    if (!(b.command == CMD_WRITE &&
                          (b.reg_index == REG_LSR || b.reg_index == REG_MSR))) begin
                        counted++;
                    end
                end
            end
        end
        s_valid <= 1'b0;

        while (due_out.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_TAIL) @(posedge aclk);

        $display("covered %0d input beats and %0d result beats under four idle patterns",
                 beats_in, results_seen);
        $display("fifo mode entered %0d times, %0d receive overruns, deepest receive fifo %0d",
                 fifo_entries, rx_overruns, rx_deepest);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
